[src/psl_pkg.sv]
// shared types and constants for the pair set with linear probing
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 256;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	// field widths
	localparam int KEY_W   = 31;
	localparam int MODE_W  = 2;
	localparam int COUNT_W = 9;
	localparam int PAIR_W  = 2 * KEY_W;

	// multiplicative hash constant
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	// insert limit after reset
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

	// item modes
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  from_key;
		logic [KEY_W-1:0]  to_key;
	} in_item_t;

	typedef struct packed {
		logic               answer;
		logic [COUNT_W-1:0] stored_count;
	} out_item_t;

endpackage

`default_nettype wire

[src/psl_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module psl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/psl_hash.sv]
// home slot hash: key multiply, xor and mask, registered
`timescale 1ns / 1ps
`default_nettype none

module psl_hash
	import psl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              start,
	input  wire logic [KEY_W-1:0]  from_key,
	input  wire logic [KEY_W-1:0]  to_key,
	output logic      [SLOT_W-1:0] slot
);

	logic [31:0]       prod;
	logic [31:0]       mixed;
	logic [SLOT_W-1:0] slot_s1;

	// low 32 bits of the product only
	assign prod  = 32'({1'b0, from_key} * HASH_MULT);
	assign mixed = prod ^ {1'b0, to_key};

	always_ff @(posedge clk) begin
		if (start) begin
			slot_s1 <= mixed[SLOT_W-1:0];
		end
	end

	assign slot = slot_s1;

endmodule

`default_nettype wire

[src/pair_set_linear_probe.sv]
// top level: pair set in an open addressed table with linear probing
// path: hash register, then per slot probed a key ram read (ST_READ) and a compare (ST_CMP),
//   then the result register; clear, unused mode and a refused insert skip the probe and go
//   straight to the result; one item at a time
// throughput: the next item is taken the cycle after the result is loaded
// reset: table empty, stored count zero, insert limit 256, no result pending
`timescale 1ns / 1ps
`default_nettype none

module pair_set_linear_probe
	import psl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]             state_q;
	logic [COUNT_W-1:0]     limit_q;
	logic [COUNT_W-1:0]     count_q;
	logic [TABLE_SLOTS-1:0] used_q;      // one occupancy flag per slot
	logic                   is_insert_q;
	logic [KEY_W-1:0]       from_q;
	logic [KEY_W-1:0]       to_q;
	logic [SLOT_W-1:0]      slot_q;      // current probe position
	logic [SLOT_W-1:0]      probes_q;    // slots visited so far
	logic                   hit_used_q;  // occupancy of the slot being read
	logic                   answer_q;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic                   in_xfer;
	logic                   hash_start;
	logic [SLOT_W-1:0]      home_slot;
	logic                   ram_we;
	logic                   ram_re;
	logic [PAIR_W-1:0]      ram_rdata;
	logic                   key_match;
	logic                   load_out;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	// hash unit: only lookups and inserts under the limit need a probe
	assign hash_start = in_xfer && ((in_data.mode == MODE_LOOKUP) ||
		((in_data.mode == MODE_INSERT) && (count_q < limit_q)));

	psl_hash u_hash (
		.clk      (clk),
		.start    (hash_start),
		.from_key (in_data.from_key),
		.to_key   (in_data.to_key),
		.slot     (home_slot)
	);

	// key store: read in ST_READ, compare in ST_CMP, write on a new insert
	assign ram_re    = (state_q == ST_READ);
	assign key_match = (ram_rdata == {from_q, to_q});
	assign ram_we    = (state_q == ST_CMP) && !hit_used_q && is_insert_q;

	psl_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (TABLE_SLOTS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({from_q, to_q}),
		.re    (ram_re),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// result register loads when empty or being drained
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (hash_start) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_DONE;
						end
						// clear empties every slot at once
						if (in_data.mode == MODE_CLEAR) begin
							used_q  <= '0;
							count_q <= '0;
						end
					end
				end
				ST_HASH: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!hit_used_q) begin
						// empty slot ends the probe; an insert takes it
						if (is_insert_q) begin
							used_q[slot_q] <= 1'b1;
							count_q        <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else if (key_match || (probes_q == SLOT_W'(TABLE_SLOTS - 1))) begin
						// found, or every slot visited
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			is_insert_q <= (in_data.mode == MODE_INSERT);
			from_q      <= in_data.from_key;
			to_q        <= in_data.to_key;
			// clear answers 1; unused mode and refused insert answer 0
			answer_q    <= (in_data.mode == MODE_CLEAR);
		end
		if (state_q == ST_HASH) begin
			slot_q   <= home_slot;
			probes_q <= '0;
		end
		if (state_q == ST_READ) begin
			hit_used_q <= used_q[slot_q];
		end
		if (state_q == ST_CMP) begin
			if (!hit_used_q) begin
				answer_q <= is_insert_q;
			end else if (key_match) begin
				answer_q <= 1'b1;
			end else if (probes_q == SLOT_W'(TABLE_SLOTS - 1)) begin
				answer_q <= 1'b0;
			end else begin
				slot_q   <= slot_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end
		end
		if (load_out) begin
			out_data_q.answer       <= answer_q;
			out_data_q.stored_count <= count_q;
		end
	end

endmodule

`default_nettype wire

[bench/pair_set_linear_probe_tb.sv]
// testbench for the pair set with linear probing: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module pair_set_linear_probe_tb;
	import psl_pkg::*;

	// run control
	localparam int           CYCLE_LIMIT   = 4_000_000;
	localparam int           SETTLE_CYCLES = 4;
	localparam int           TAIL_CYCLES   = 20;
	localparam int           POOL_N        = 48;
	localparam int           HOLD_CYCLES   = 400;
	localparam int           HOLD_AT       = 100;
	localparam logic [KEY_W-1:0]  KEY_MAX     = 31'h7fff_ffff;
	// mode 3 has no name in the package, the block must treat it as a no-op
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [1:0] {PROBE_FULL, PROBE_EMPTY, PROBE_HIT} probe_t;
	typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

	// one line of the directed table: either an item or a limit write
	typedef struct {
		row_kind_t          kind;
		in_item_t           item;
		logic [COUNT_W-1:0] limit;
		bit                 typed;
		out_item_t          want;
	} drow_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [COUNT_W-1:0] cfg_data;

	// mirror of the set kept by the bench
	bit                 slot_taken [TABLE_SLOTS];
	logic [KEY_W-1:0]   slot_from  [TABLE_SLOTS];
	logic [KEY_W-1:0]   slot_to    [TABLE_SLOTS];
	logic [COUNT_W-1:0] held_count;
	logic [COUNT_W-1:0] insert_cap;

	// answers owed by the block, oldest first
	out_item_t answers_due [$];

	// pairs that keep coming back, grouped so that each group shares a home slot
	logic [KEY_W-1:0] pool_from [POOL_N];
	logic [KEY_W-1:0] pool_to   [POOL_N];

	drow_t plan [$];

	int  failures;
	int  items_sent;
	int  results_seen;
	int  cycle_count;
	bit  calm;

	pair_set_linear_probe uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// answer and new count for one item, updating the mirror
	function automatic out_item_t pair_set_answer(in_item_t it);
		out_item_t         res;
		logic [31:0]       mixed;
		logic [SLOT_W-1:0] slot;
		probe_t            found;
		int                n;
		res.answer = 1'b0;
		if (it.mode == MODE_LOOKUP || (it.mode == MODE_INSERT && held_count < insert_cap)) begin
			// multiplicative hash kept to 32 bits, then folded with the second key
			mixed = {1'b0, it.from_key} * HASH_MULT;
			slot  = mixed[SLOT_W-1:0] ^ it.to_key[SLOT_W-1:0];
			found = PROBE_FULL;
			for (n = 0; n < TABLE_SLOTS && found == PROBE_FULL; n++) begin
				if (!slot_taken[slot])
					found = PROBE_EMPTY;
				else if (slot_from[slot] == it.from_key && slot_to[slot] == it.to_key)
					found = PROBE_HIT;
				else
					slot = slot + 1'b1;
			end
			if (found == PROBE_HIT) begin
				res.answer = 1'b1;
			end else if (found == PROBE_EMPTY && it.mode == MODE_INSERT) begin
				slot_taken[slot] = 1'b1;
				slot_from[slot]  = it.from_key;
				slot_to[slot]    = it.to_key;
				held_count       = held_count + 1'b1;
				res.answer       = 1'b1;
			end
		end else if (it.mode == MODE_CLEAR) begin
			slot_taken = '{default: 1'b0};
			held_count = '0;
			res.answer = 1'b1;
		end
		// refused inserts and mode 3 fall through with answer 0
		res.stored_count = held_count;
		return res;
	endfunction

	function automatic drow_t op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] a,
		logic [KEY_W-1:0] b);
		drow_t row;
		row.kind  = ROW_ITEM;
		row.item  = '{mode: m, from_key: a, to_key: b};
		row.limit = '0;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	// item whose answer is obvious enough to write down
	function automatic drow_t op_w(logic [MODE_W-1:0] m, logic [KEY_W-1:0] a,
		logic [KEY_W-1:0] b, logic ans, logic [COUNT_W-1:0] cnt);
		drow_t row;
		row       = op(m, a, b);
		row.typed = 1'b1;
		row.want  = '{answer: ans, stored_count: cnt};
		return row;
	endfunction

	function automatic drow_t lim(logic [COUNT_W-1:0] v);
		drow_t row;
		row       = op(MODE_LOOKUP, '0, '0);
		row.kind  = ROW_LIMIT;
		row.limit = v;
		return row;
	endfunction

	// random item: mostly pooled pairs so inserts and lookups meet again
	function automatic in_item_t draw_item(int clear_pct, int insert_pct, bit fresh);
		in_item_t    it;
		int          pick;
		int          k;
		logic [31:0] r1;
		logic [31:0] r2;
		pick = $urandom_range(99);
		k    = $urandom_range(POOL_N - 1);
		r1   = $urandom();
		r2   = $urandom();
		if (pick < clear_pct)
			it.mode = MODE_CLEAR;
		else if (pick < clear_pct + 3)
			it.mode = MODE_UNUSED;
		else if ($urandom_range(99) < insert_pct)
			it.mode = MODE_INSERT;
		else
			it.mode = MODE_LOOKUP;
		if (fresh || $urandom_range(99) < 12) begin
			it.from_key = r1[KEY_W-1:0];
			it.to_key   = r2[KEY_W-1:0];
		end else if ($urandom_range(99) < 10) begin
			// near miss: same home slot as a pooled pair, different upper bits
			it.from_key = pool_from[k];
			it.to_key   = {r2[KEY_W-1:SLOT_W], pool_to[k][SLOT_W-1:0]};
		end else begin
			it.from_key = pool_from[k];
			it.to_key   = pool_to[k];
		end
		return it;
	endfunction

	// offer one item, wait for its transfer, then book the answer it owes
	task automatic offer(in_item_t it, bit typed, out_item_t want);
		out_item_t got;
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		got = pair_set_answer(it);
		answers_due.push_back(typed ? want : got);
		items_sent++;
		calm = (items_sent >= 500 && items_sent < 700);
	endtask

	// stop offering until every owed answer is back and the block is idle
	task automatic settle();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(logic [COUNT_W-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		insert_cap = v;
	endtask

	task automatic burst(int n, int clear_pct, int insert_pct, bit fresh);
		int i;
		for (i = 0; i < n; i++)
			offer(draw_item(clear_pct, insert_pct, fresh), 1'b0, '0);
	endtask

	// result side: check every transfer, stall at random and once for a long stretch
	initial begin : result_side
		out_item_t due;
		int        hold_left;
		bit        hold_used;
		out_ready <= 1'b0;
		hold_left = 0;
		hold_used = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$error("result with nothing owed: answer %0d, stored_count %0d",
						out_data.answer, out_data.stored_count);
					failures++;
				end else begin
					due = answers_due.pop_front();
					if (out_data.answer !== due.answer) begin
						$error("answer: expected %0d, got %0d", due.answer, out_data.answer);
						failures++;
					end
					if (out_data.stored_count !== due.stored_count) begin
						$error("stored_count: expected %0d, got %0d",
							due.stored_count, out_data.stored_count);
						failures++;
					end
				end
				results_seen++;
			end
			// long hold-off so the block fills and pushes back on its input
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_used && results_seen == HOLD_AT) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 15;
			end
		end
	end

	// watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pair_set_linear_probe_tb: errors");
		$finish;
	end

	initial begin : stimulus
		int          i;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		failures     = 0;
		items_sent   = 0;
		results_seen = 0;
		calm         = 1'b0;

		// mirror starts as the block does after reset
		slot_taken = '{default: 1'b0};
		slot_from  = '{default: '0};
		slot_to    = '{default: '0};
		held_count = '0;
		insert_cap = LIMIT_RESET;

		// pool: groups of six pairs on one from key and one low byte of the to key
		for (i = 0; i < POOL_N; i++) begin
			if (i % 6 == 0) begin
				r1 = $urandom();
				r3 = $urandom();
			end
			r2 = $urandom();
			pool_from[i] = r1[KEY_W-1:0];
			pool_to[i]   = {r2[KEY_W-1:SLOT_W], r3[SLOT_W-1:0]};
		end

		// directed table, limit at its reset value to start with
		plan.push_back(op_w(MODE_LOOKUP, '0, '0, 1'b0, 9'd0));      // empty after reset
		plan.push_back(op_w(MODE_INSERT, '0, '0, 1'b1, 9'd1));
		plan.push_back(op_w(MODE_INSERT, '0, '0, 1'b1, 9'd1));      // duplicate accepted
		plan.push_back(op_w(MODE_LOOKUP, '0, '0, 1'b1, 9'd1));
		plan.push_back(op_w(MODE_INSERT, KEY_MAX, KEY_MAX, 1'b1, 9'd2));
		plan.push_back(op_w(MODE_LOOKUP, KEY_MAX, '0, 1'b0, 9'd2));
		plan.push_back(op_w(MODE_UNUSED, KEY_MAX, KEY_MAX, 1'b0, 9'd2));
		// three pairs on one home slot: a probe chain
		plan.push_back(op(MODE_INSERT, 31'd3, 31'h100));
		plan.push_back(op(MODE_INSERT, 31'd3, 31'h200));
		plan.push_back(op(MODE_LOOKUP, 31'd3, 31'h200));
		plan.push_back(op(MODE_LOOKUP, 31'd3, 31'h300));
		// limit reached: refused even for a pair already held
		plan.push_back(lim(9'd4));
		plan.push_back(op_w(MODE_INSERT, 31'd3, 31'h300, 1'b0, 9'd4));
		plan.push_back(op_w(MODE_INSERT, '0, '0, 1'b0, 9'd4));
		// zero limit
		plan.push_back(lim(9'd0));
		plan.push_back(op_w(MODE_CLEAR, KEY_MAX, '0, 1'b1, 9'd0));
		plan.push_back(op_w(MODE_INSERT, 31'd5, 31'd5, 1'b0, 9'd0));
		// widest limit, above the table size
		plan.push_back(lim(9'd511));
		plan.push_back(op_w(MODE_INSERT, KEY_MAX, '0, 1'b1, 9'd1));
		plan.push_back(op_w(MODE_LOOKUP, '0, KEY_MAX, 1'b0, 9'd1));
		plan.push_back(op_w(MODE_CLEAR, '0, '0, 1'b1, 9'd0));
		plan.push_back(lim(9'd256));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_LIMIT)
				set_limit(plan[i].limit);
			else
				offer(plan[i].item, plan[i].typed, plan[i].want);
		end

		// mixed traffic on pooled pairs, with one full pause in the middle
		burst(175, 2, 55, 1'b0);
		settle();
		burst(175, 2, 55, 1'b0);

		// fill the table to the last slot, then keep inserting into a full table
		set_limit(9'd511);
		offer('{mode: MODE_CLEAR, from_key: '0, to_key: '0}, 1'b1,
			'{answer: 1'b1, stored_count: 9'd0});
		burst(340, 0, 90, 1'b1);

		// full table with the limit at the table size: refused before probing
		set_limit(9'd256);
		burst(30, 0, 70, 1'b0);

		// tightest limits, clears bring the count back down
		set_limit(9'd1);
		burst(150, 8, 60, 1'b0);
		set_limit(9'd0);
		burst(60, 5, 60, 1'b0);

		// a few limits anywhere in range
		for (i = 0; i < 3; i++) begin
			set_limit(COUNT_W'($urandom_range(1, 256)));
			burst(150, 4, 60, 1'b0);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && answers_due.size() == 0)
			$display("pair_set_linear_probe_tb: clean");
		else
			$display("pair_set_linear_probe_tb: errors");
		$finish;
	end

endmodule
